/* design/u2h_pkg.sv */
// shared types, constants and helpers for the utf-8 to ucs-2 hex encoder
`default_nettype none

package u2h_pkg;

  // input item: one byte of utf-8 text
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  // output item: one ascii hex digit
  typedef struct packed {
    logic [6:0] hex_char;
    logic       last_of_run;
    logic       text_done;
  } out_item_t;

  // decoded work for one input byte: one or two code points
  typedef struct packed {
    logic        two;
    logic [15:0] cp0;
    logic [15:0] cp1;
    logic        eot;
  } cp_job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int QDepth = 2;

  localparam logic [15:0] QMARK_CP        = 16'h003F;
  localparam logic [7:0]  ASCII_LIMIT     = 8'h80;
  localparam logic [6:0]  CHAR_ZERO       = 7'h30;
  localparam logic [6:0]  CHAR_ALPHA_BASE = 7'h37;

  // held byte counts
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // nibble to upper-case ascii hex digit
  function automatic logic [6:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return CHAR_ZERO + {3'b000, n};
    end else begin
      return CHAR_ALPHA_BASE + {3'b000, n};
    end
  endfunction

  // single byte standing alone at the end of text
  function automatic logic [15:0] lone_at_end(input logic [7:0] b);
    if (b < ASCII_LIMIT) begin
      return {8'h00, b};
    end else begin
      return QMARK_CP;
    end
  endfunction

endpackage

`default_nettype wire

/* design/u2h_front.sv */
// front end: accepts utf-8 bytes, tracks held lead bytes, emits code point jobs
`default_nettype none

module u2h_front
  import u2h_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     src_valid,
  output logic          src_ready,
  input  wire in_item_t src_data,
  input  wire q_stat_t  q_stat,
  output logic          q_push,
  output cp_job_t       q_job
);

  logic [7:0] lead_held, lead_held_next;
  logic [7:0] second_held, second_held_next;
  logic [1:0] held_count, held_count_next;
  logic       accept;
  logic       produce;
  logic [7:0] b;
  logic       eot;

  assign src_ready = !q_stat.full;
  assign accept    = src_valid && src_ready;
  assign b         = src_data.in_byte;
  assign eot       = src_data.end_of_text;
  assign q_push    = accept && produce;

  // decode of the current byte against held state
  always_comb begin
    lead_held_next   = lead_held;
    second_held_next = second_held;
    held_count_next  = HELD_NONE;
    produce          = 1'b0;
    q_job.two        = 1'b0;
    q_job.cp0        = QMARK_CP;
    q_job.cp1        = QMARK_CP;
    q_job.eot        = eot;
    if (held_count == HELD_ONE && lead_held[7:5] == 3'b110) begin
      produce   = 1'b1;
      q_job.cp0 = {5'b00000, lead_held[4:0], b[5:0]};
    end else if (held_count == HELD_ONE) begin
      if (eot) begin
        // cut-off three-byte lead, then the byte decoded alone
        produce   = 1'b1;
        q_job.two = 1'b1;
        q_job.cp1 = lone_at_end(b);
      end else begin
        second_held_next = b;
        held_count_next  = HELD_TWO;
      end
    end else if (held_count == HELD_TWO) begin
      produce   = 1'b1;
      q_job.cp0 = {lead_held[3:0], second_held[5:0], b[5:0]};
    end else begin
      if (b < ASCII_LIMIT) begin
        produce   = 1'b1;
        q_job.cp0 = {8'h00, b};
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
        if (eot) begin
          produce = 1'b1;
        end else begin
          lead_held_next  = b;
          held_count_next = HELD_ONE;
        end
      end else begin
        produce = 1'b1;
      end
    end
    if (eot) begin
      held_count_next = HELD_NONE;
    end
  end

  // held state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held   <= 8'h00;
      second_held <= 8'h00;
      held_count  <= HELD_NONE;
    end else if (accept) begin
      lead_held   <= lead_held_next;
      second_held <= second_held_next;
      held_count  <= held_count_next;
    end
  end

endmodule

`default_nettype wire

/* design/u2h_queue.sv */
// short job queue between front and back
`default_nettype none

module u2h_queue
  import u2h_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire cp_job_t push_job,
  input  wire logic    pop,
  output cp_job_t      head,
  output q_stat_t      stat
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  cp_job_t             slots [QDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign stat.full  = (count == CntW'(QDepth));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/u2h_back.sv */
// back end: serializes code points into hex digits through an output register
`default_nettype none

module u2h_back
  import u2h_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cp_job_t head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         dst_valid,
  input  wire logic    dst_ready,
  output out_item_t    dst_data
);

  logic [2:0]  idx;
  logic        load;
  logic        final_char;
  logic [15:0] cp;
  logic [3:0]  nib;

  assign load       = !q_stat.empty && (!dst_valid || dst_ready);
  assign final_char = (idx == (head.two ? 3'd7 : 3'd3));
  assign pop        = load && final_char;
  assign cp         = idx[2] ? head.cp1 : head.cp0;

  // nibble select, most significant first
  always_comb begin
    case (idx[1:0])
      2'd0:    nib = cp[15:12];
      2'd1:    nib = cp[11:8];
      2'd2:    nib = cp[7:4];
      default: nib = cp[3:0];
    endcase
  end

  // output register and digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      dst_valid <= 1'b1;
      idx       <= final_char ? 3'd0 : idx + 3'd1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      dst_data.hex_char    <= hex_digit(nib);
      dst_data.last_of_run <= final_char;
      dst_data.text_done   <= final_char && head.eot;
    end
  end

endmodule

`default_nettype wire

/* design/utf8_to_ucs2_hex_encoder_unit.sv */
// top level of the utf-8 to ucs-2 hex encoder
`default_nettype none

// Takes UTF-8 text one byte per transfer and returns each decoded code point
// as four upper-case ASCII hex digits, most significant first. The front end
// takes one byte per cycle while its two-entry job queue has room; the back
// end sends one digit per cycle from its output register while the queue holds
// a job and the receiver is ready. An ASCII byte or a completed multi-byte
// sequence gives four digits, so the one-digit-per-cycle output sets sustained
// throughput. A three-byte lead cut off by end of text on the byte after it
// gives eight digits. Lead bytes that are held give no digits. A byte's first
// digit passes through the queue slot and then the output register.
module utf8_to_ucs2_hex_encoder_unit
  import u2h_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_ready,
  input  wire in_item_t  src_data,
  output logic           dst_valid,
  input  wire logic      dst_ready,
  output out_item_t      dst_data
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cp_job_t q_job;
  cp_job_t q_head;

  // byte intake and decode
  u2h_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // job queue
  u2h_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // digit serializer
  u2h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

`ifndef SYNTHESIS
  // end of text always closes a run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.text_done |-> dst_data.last_of_run)
    else $error("text_done without last_of_run");

  // only hex digits leave the block
  a_hex_range: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> ((dst_data.hex_char >= 7'h30 && dst_data.hex_char <= 7'h39) ||
                   (dst_data.hex_char >= 7'h41 && dst_data.hex_char <= 7'h46)))
    else $error("output is not a hex digit");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("job queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

/* bench/u2h_digit_checker.sv */
// checker for the utf-8 to ucs-2 hex encoder: predicts digits and compares them
`timescale 1ns / 100ps
`default_nettype none

module u2h_digit_checker
  import u2h_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  input  wire logic      src_ready,
  input  wire in_item_t  src_data,
  input  wire logic      dst_valid,
  input  wire logic      dst_ready,
  input  wire out_item_t dst_data,
  output int             fail_count,
  output int             pending,
  output int             bytes_seen,
  output int             digits_seen
);

  localparam logic [15:0] QUESTION_CP = 16'h003F;

  // predictor state: held lead byte, held second byte, number held
  logic [7:0] lead_byte;
  logic [7:0] mid_byte;
  logic [1:0] held_bytes;

  // expected hex digits, oldest first
  out_item_t digit_q[$];
  out_item_t want;

  // ascii hex digit for one nibble
  function automatic logic [6:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return {3'b011, nib};
    end else begin
      return 7'h37 + {3'b000, nib};
    end
  endfunction

  // decode one accepted byte and queue the digits it causes
  function automatic void predict_digits(input in_item_t it);
    logic [15:0] cps [2];
    int          ncp;
    logic [7:0]  b;
    logic        eot;
    out_item_t   d;
    ncp = 0;
    b   = it.in_byte;
    eot = it.end_of_text;
    cps[0] = '0;
    cps[1] = '0;
    case (held_bytes)
      HELD_ONE: begin
        if (lead_byte[7:5] == 3'b110) begin
          cps[0] = {5'b00000, lead_byte[4:0], b[5:0]};
          ncp = 1;
          held_bytes = HELD_NONE;
        end else if (eot) begin
          // three-byte lead cut off: '?' then the byte on its own
          cps[0] = QUESTION_CP;
          cps[1] = b[7] ? QUESTION_CP : {8'h00, b};
          ncp = 2;
          held_bytes = HELD_NONE;
        end else begin
          mid_byte = b;
          held_bytes = HELD_TWO;
        end
      end
      HELD_TWO: begin
        cps[0] = {lead_byte[3:0], mid_byte[5:0], b[5:0]};
        ncp = 1;
        held_bytes = HELD_NONE;
      end
      default: begin
        held_bytes = HELD_NONE;
        if (!b[7]) begin
          cps[0] = {8'h00, b};
          ncp = 1;
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
          if (eot) begin
            cps[0] = QUESTION_CP;
            ncp = 1;
          end else begin
            lead_byte = b;
            held_bytes = HELD_ONE;
          end
        end else begin
          cps[0] = QUESTION_CP;
          ncp = 1;
        end
      end
    endcase
    if (eot) begin
      held_bytes = HELD_NONE;
    end
    // four digits per code point, most significant nibble first
    for (int i = 0; i < ncp; i++) begin
      for (int k = 0; k < 4; k++) begin
        d.hex_char    = nibble_char(cps[i][15 - 4 * k -: 4]);
        d.last_of_run = (i == ncp - 1) && (k == 3);
        d.text_done   = d.last_of_run && eot;
        digit_q.insert(digit_q.size(), d);
      end
    end
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      lead_byte   = '0;
      mid_byte    = '0;
      held_bytes  = HELD_NONE;
      digit_q.delete();
      fail_count  = 0;
      bytes_seen  = 0;
      digits_seen = 0;
    end else begin
      // input transfer: predict
      if (src_valid && src_ready) begin
        predict_digits(src_data);
        bytes_seen++;
      end
      // output transfer: compare with the oldest expectation
      if (dst_valid && dst_ready) begin
        digits_seen++;
        if (digit_q.size() == 0) begin
          $display("%0t: unexpected digit: got char %h last %b done %b", $time,
                   dst_data.hex_char, dst_data.last_of_run, dst_data.text_done);
          fail_count++;
        end else begin
          want = digit_q.pop_front();
          if (dst_data.hex_char !== want.hex_char ||
              dst_data.last_of_run !== want.last_of_run ||
              dst_data.text_done !== want.text_done) begin
            $display({"%0t: digit mismatch: expected char %h last %b done %b, ",
                      "got char %h last %b done %b"},
                     $time, want.hex_char, want.last_of_run, want.text_done,
                     dst_data.hex_char, dst_data.last_of_run, dst_data.text_done);
            fail_count++;
          end
        end
      end
    end
    pending = digit_q.size();
  end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench top for the utf-8 to ucs-2 hex encoder: stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import u2h_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseBytes = 36;

  logic      clk = 1'b1;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_item_t  src_data = '0;
  logic      dst_valid;
  logic      dst_ready = 1'b0;
  out_item_t dst_data;

  int fail_count;
  int pending;
  int bytes_seen;
  int digits_seen;
  int send_idle_pct = 10;
  int recv_stall_pct = 68;
  int quiet_cycles = 0;

  utf8_to_ucs2_hex_encoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

  u2h_digit_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .src_data    (src_data),
    .dst_valid   (dst_valid),
    .dst_ready   (dst_ready),
    .dst_data    (dst_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .bytes_seen  (bytes_seen),
    .digits_seen (digits_seen)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    dst_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((src_valid && src_ready) || (dst_valid && dst_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("utf8_to_ucs2_hex_encoder_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte transfer, with a random idle gap before it
  task automatic send_byte(input logic [7:0] b, input logic eot);
    if ($urandom_range(99) < send_idle_pct) begin
      src_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    src_valid <= 1'b1;
    src_data  <= '{in_byte: b, end_of_text: eot};
    do @(posedge clk); while (!src_ready);
    @(negedge clk);
  endtask

  // hold the sender until every expected digit has come
  task automatic drain;
    src_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // one piece of random text: mostly well-formed, some broken or noise
  task automatic send_random_text(output int count);
    logic [7:0] seq [3];
    int         n;
    int         kind;
    kind = $urandom_range(99);
    n = 1;
    if (kind < 35) begin
      seq[0] = 8'($urandom_range(127));
    end else if (kind < 55) begin
      seq[0] = {3'b110, 5'($urandom_range(31))};
      seq[1] = {2'b10, 6'($urandom_range(63))};
      n = 2;
    end else if (kind < 75) begin
      seq[0] = {4'b1110, 4'($urandom_range(15))};
      seq[1] = {2'b10, 6'($urandom_range(63))};
      seq[2] = {2'b10, 6'($urandom_range(63))};
      n = 3;
    end else if (kind < 88) begin
      // lead followed by arbitrary bytes
      seq[0] = $urandom_range(1) ? {3'b110, 5'($urandom_range(31))}
                                 : {4'b1110, 4'($urandom_range(15))};
      seq[1] = 8'($urandom_range(255));
      seq[2] = 8'($urandom_range(255));
      n = $urandom_range(1, 3);
    end else begin
      seq[0] = 8'($urandom_range(255));
    end
    for (int i = 0; i < n; i++) begin
      send_byte(seq[i], $urandom_range(11) == 0);
    end
    count = n;
  endtask

  // stimulus
  initial begin
    int sent;
    int chunk;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ascii extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // two-byte forms, incl. top of range and non-continuation second byte
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h00, 1'b0);
    // three-byte forms, last one completed on the end of text
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // bytes that are neither ascii nor a lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    // lead cut off by the end of text
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'hC3, 1'b1);
    // ascii on the end of text
    send_byte(8'h41, 1'b1);
    drain();

    // random text in three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 68;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        send_random_text(chunk);
        sent += chunk;
      end
      drain();
    end

    // tail: let the block settle
    src_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d input bytes (directed and random, three idle patterns)", bytes_seen);
    $display("checked %0d hex digits, %0d failures", digits_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("utf8_to_ucs2_hex_encoder_unit regression: pass");
    end else begin
      $display("utf8_to_ucs2_hex_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
